FILE: rtl/grid_astar_path_search_top_macros.svh
// Assertion macros shared by the grid path search RTL.
// Included by the controller and the datapath; needs clk_i and rst_ni in scope.
`ifndef GRID_ASTAR_PATH_SEARCH_TOP_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GAPS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define GAPS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GAPS_ASSERT(name, prop)
`define GAPS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: rtl/gaps_pkg.sv
// Types, constants and helper functions of the grid path search block.
// Used by the controller, the datapath and the top level; depends on nothing.
package gaps_pkg;

  localparam int unsigned CoordW = 3;
  localparam int unsigned CellW = 6;
  localparam int unsigned CostW = 16;
  localparam int unsigned CostStraight = 10;
  localparam int unsigned CostDiagonal = 14;

  typedef struct packed {
    logic       operation;
    logic [2:0] cell_x;
    logic [2:0] cell_y;
    logic       passable;
    logic [2:0] start_x;
    logic [2:0] start_y;
    logic [2:0] goal_x;
    logic [2:0] goal_y;
  } in_item_t;

  typedef struct packed {
    logic [2:0] path_x;
    logic [2:0] path_y;
    logic       last;
    logic       not_found;
  } out_item_t;

  typedef enum logic [1:0] {
    OUT_NOT_FOUND,
    OUT_START,
    OUT_CHAIN
  } out_sel_e;

  typedef struct packed {
    logic     accept;
    logic     init;
    logic     scan_clr;
    logic     scan_run;
    logic     pop;
    logic     expand;
    logic     trace_init;
    logic     trace_step;
    logic     trace_load;
    logic     emit_dec;
    logic     out_load;
    out_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic bad_coord;
    logic same_cell;
    logic open_any;
    logic scan_done;
    logic goal_hit;
    logic dir_last;
    logic trace_end;
    logic emit_first;
    logic out_free;
  } status_t;

  // Move offsets in two's complement, straight moves first, then diagonals.
  function automatic logic [4:0] move_dx(input logic [2:0] d);
    logic [4:0] r;
    unique case (d)
      3'd0, 3'd4, 3'd7: r = 5'h1f;
      3'd2, 3'd5, 3'd6: r = 5'h01;
      default:          r = 5'h00;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] move_dy(input logic [2:0] d);
    logic [4:0] r;
    unique case (d)
      3'd1, 3'd4, 3'd5: r = 5'h1f;
      3'd3, 3'd6, 3'd7: r = 5'h01;
      default:          r = 5'h00;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] move_cost(input logic [2:0] d);
    return d[2] ? 5'(CostDiagonal) : 5'(CostStraight);
  endfunction

  // Diagonal cost times the Chebyshev distance.
  function automatic logic [15:0] heur(input logic [2:0] x, input logic [2:0] y,
                                       input logic [2:0] gx, input logic [2:0] gy);
    logic [2:0] ax;
    logic [2:0] ay;
    logic [2:0] m;
    ax = (x > gx) ? x - gx : gx - x;
    ay = (y > gy) ? y - gy : gy - y;
    m  = (ax > ay) ? ax : ay;
    return 16'({13'd0, m} * 16'(CostDiagonal));
  endfunction

endpackage

FILE: rtl/grid_astar_path_search_top.sv
// Top level of the grid path search block; joins gaps_ctrl and gaps_dp.
// Depends on gaps_pkg, gaps_ctrl and gaps_dp.
//
// A map load transaction is taken in the idle state without leaving it. A run checks its
// coordinates and sets up, then for every cell popped from the open set scans all 64
// open-set entries, one entry per cycle through the cost memory's read port, and
// expands up to eight neighbor moves in turn, then traces parents back from the goal
// and emits one path cell at a time, each emission waiting for a free output register.
// Input is stalled for the whole run; the last result may still wait in
// the output register while the next transaction is taken.
module grid_astar_path_search_top #(
  parameter int unsigned MAP_SIDE = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gaps_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gaps_pkg::out_item_t out_data_o
);

  gaps_pkg::cmd_t    cmd;
  gaps_pkg::status_t sts;

  gaps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .run_i      (in_data_i.operation),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gaps_dp #(
    .MAP_SIDE (MAP_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/gaps_dp.sv
// Datapath of the grid path search: map, open set, parents, path stack, output register.
// Uses gaps_pkg and the assertion macros header; driven by gaps_ctrl commands.
`include "grid_astar_path_search_top_macros.svh"
module gaps_dp #(
  parameter int unsigned MAP_SIDE = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gaps_pkg::in_item_t  in_data_i,
  input  gaps_pkg::cmd_t      cmd_i,
  input  logic                out_stall_i,
  output gaps_pkg::status_t   sts_o,
  output logic                out_valid_o,
  output gaps_pkg::out_item_t out_data_o
);

  localparam logic [3:0] Side = 4'(MAP_SIDE);

  logic [63:0] passable_q;
  logic [63:0] closed_q;
  logic [63:0] open_q;
  logic [31:0] fg_mem [64];
  logic [5:0]  parent_mem [64];
  logic [5:0]  chain_mem [64];

  logic [2:0]  start_x_q, start_y_q, goal_x_q, goal_y_q;
  logic [5:0]  start_cell, goal_cell;

  logic [6:0]  scan_idx_q;
  logic        rd_vld_q;
  logic [5:0]  rd_idx_q;
  logic [31:0] rd_fg_q;
  logic        best_vld_q;
  logic [37:0] best_key_q;
  logic [37:0] cand_key;

  logic [5:0]  cur_q;
  logic [15:0] g0_q;
  logic [2:0]  dir_q;

  logic [4:0]  nx, ny;
  logic        nb_in;
  logic [5:0]  nb_cell;
  logic [16:0] g_full;
  logic [17:0] f_full;
  logic [15:0] f_sat;
  logic        nb_goal;
  logic        push;

  logic [5:0]  trace_q;
  logic [5:0]  parent_rd_q;
  logic [5:0]  n_q;
  logic [5:0]  chain_rd_q;

  logic        out_valid_q;
  gaps_pkg::out_item_t out_q;

  logic        fg_we;
  logic [5:0]  fg_waddr;
  logic [31:0] fg_wdata;
  logic        par_we;
  logic [5:0]  par_waddr;
  logic [5:0]  par_wdata;

  assign start_cell = {start_y_q, start_x_q};
  assign goal_cell  = {goal_y_q, goal_x_q};

  // Neighbor under the current move.
  assign nx      = {2'b00, cur_q[2:0]} + gaps_pkg::move_dx(dir_q);
  assign ny      = {2'b00, cur_q[5:3]} + gaps_pkg::move_dy(dir_q);
  assign nb_in   = !nx[4] && !ny[4] && (nx[3:0] < Side) && (ny[3:0] < Side);
  assign nb_cell = {ny[2:0], nx[2:0]};
  assign g_full  = {1'b0, g0_q} + 17'(gaps_pkg::move_cost(dir_q));
  assign f_full  = {1'b0, g_full} +
                   18'(gaps_pkg::heur(nx[2:0], ny[2:0], goal_x_q, goal_y_q));
  assign f_sat   = (f_full > 18'h0ffff) ? 16'hffff : f_full[15:0];
  assign nb_goal = nb_in && (nb_cell == goal_cell);
  // A neighbor whose cost saturates to all ones is never pushed into the open set.
  assign push    = cmd_i.expand && nb_in && !nb_goal && passable_q[nb_cell] &&
                   !closed_q[nb_cell] && (f_sat != 16'hffff);

  assign cand_key = {rd_fg_q, rd_idx_q};

  always_comb begin
    fg_we     = cmd_i.init || push;
    fg_waddr  = cmd_i.init ? start_cell : nb_cell;
    fg_wdata  = cmd_i.init ?
                {gaps_pkg::heur(start_x_q, start_y_q, goal_x_q, goal_y_q), 16'd0} :
                {f_sat, g_full[15:0]};
    par_we    = cmd_i.init || push || (cmd_i.expand && nb_goal);
    par_waddr = cmd_i.init ? start_cell : nb_cell;
    par_wdata = cmd_i.init ? start_cell : cur_q;
  end

  always_ff @(posedge clk_i) begin
    if (fg_we) begin
      fg_mem[fg_waddr] <= fg_wdata;
    end
    if (par_we) begin
      parent_mem[par_waddr] <= par_wdata;
    end
    if (cmd_i.trace_step) begin
      chain_mem[n_q] <= trace_q;
    end
    rd_fg_q     <= fg_mem[scan_idx_q[5:0]];
    parent_rd_q <= parent_mem[trace_q];
    chain_rd_q  <= chain_mem[n_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      start_x_q <= in_data_i.start_x;
      start_y_q <= in_data_i.start_y;
      goal_x_q  <= in_data_i.goal_x;
      goal_y_q  <= in_data_i.goal_y;
    end
    if (cmd_i.scan_run) begin
      rd_idx_q <= scan_idx_q[5:0];
    end
    if (cmd_i.scan_run && rd_vld_q && open_q[rd_idx_q] &&
        (!best_vld_q || (cand_key < best_key_q))) begin
      best_key_q <= cand_key;
    end
    if (cmd_i.pop) begin
      cur_q <= best_key_q[5:0];
      g0_q  <= best_key_q[21:6];
    end
    if (cmd_i.trace_init) begin
      trace_q <= goal_cell;
    end else if (cmd_i.trace_load) begin
      trace_q <= parent_rd_q;
    end
    if (cmd_i.out_load) begin
      unique case (cmd_i.out_sel)
        gaps_pkg::OUT_START: out_q <= '{path_x: start_x_q, path_y: start_y_q,
                                        last: 1'b1, not_found: 1'b0};
        gaps_pkg::OUT_CHAIN: out_q <= '{path_x: chain_rd_q[2:0], path_y: chain_rd_q[5:3],
                                        last: (n_q == 6'd0), not_found: 1'b0};
        default:             out_q <= '{path_x: 3'd0, path_y: 3'd0,
                                        last: 1'b1, not_found: 1'b1};
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      passable_q  <= '0;
      closed_q    <= '0;
      open_q      <= '0;
      scan_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
      best_vld_q  <= 1'b0;
      dir_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && !in_data_i.operation &&
          ({1'b0, in_data_i.cell_x} < Side) && ({1'b0, in_data_i.cell_y} < Side)) begin
        passable_q[{in_data_i.cell_y, in_data_i.cell_x}] <= in_data_i.passable;
      end
      if (cmd_i.init) begin
        closed_q <= 64'd1 << start_cell;
        open_q   <= 64'd1 << start_cell;
      end else if (push) begin
        closed_q[nb_cell] <= 1'b1;
        open_q[nb_cell]   <= 1'b1;
      end else if (cmd_i.pop) begin
        open_q[best_key_q[5:0]] <= 1'b0;
      end
      if (cmd_i.scan_clr) begin
        scan_idx_q <= '0;
        rd_vld_q   <= 1'b0;
        best_vld_q <= 1'b0;
      end else if (cmd_i.scan_run) begin
        rd_vld_q <= !scan_idx_q[6];
        if (!scan_idx_q[6]) begin
          scan_idx_q <= scan_idx_q + 7'd1;
        end
        if (rd_vld_q && open_q[rd_idx_q]) begin
          best_vld_q <= 1'b1;
        end
      end
      if (cmd_i.pop) begin
        dir_q <= '0;
      end else if (cmd_i.expand) begin
        dir_q <= dir_q + 3'd1;
      end
      if (cmd_i.trace_init) begin
        n_q <= '0;
      end else if (cmd_i.trace_step && !sts_o.trace_end) begin
        n_q <= n_q + 6'd1;
      end else if (cmd_i.emit_dec) begin
        n_q <= n_q - 6'd1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.bad_coord  = ({1'b0, start_x_q} >= Side) || ({1'b0, start_y_q} >= Side) ||
                       ({1'b0, goal_x_q} >= Side) || ({1'b0, goal_y_q} >= Side);
    sts_o.same_cell  = (start_cell == goal_cell);
    sts_o.open_any   = |open_q;
    sts_o.scan_done  = scan_idx_q[6] && !rd_vld_q;
    sts_o.goal_hit   = nb_goal;
    sts_o.dir_last   = (dir_q == 3'd7);
    sts_o.trace_end  = (trace_q == start_cell) || (&n_q);
    sts_o.emit_first = (n_q == 6'd0);
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `GAPS_ASSERT(a_push_fresh, push |-> !closed_q[nb_cell])
  `GAPS_ASSERT(a_pop_open, cmd_i.pop |-> (best_vld_q && open_q[best_key_q[5:0]]))

endmodule

FILE: rtl/gaps_ctrl.sv
// Sequencer of the grid path search: load, search, path trace and result emission.
// Uses gaps_pkg and the assertion macros header; drives gaps_dp by commands.
`include "grid_astar_path_search_top_macros.svh"
module gaps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              run_i,
  output logic              in_stall_o,
  input  gaps_pkg::status_t sts_i,
  output gaps_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] StIdle      = 4'd0;
  localparam logic [3:0] StCheck     = 4'd1;
  localparam logic [3:0] StPopDec    = 4'd2;
  localparam logic [3:0] StScan      = 4'd3;
  localparam logic [3:0] StExpand    = 4'd4;
  localparam logic [3:0] StTrace     = 4'd5;
  localparam logic [3:0] StTraceWait = 4'd6;
  localparam logic [3:0] StEmitRd    = 4'd7;
  localparam logic [3:0] StEmitOut   = 4'd8;
  localparam logic [3:0] StNotFound  = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.out_sel = gaps_pkg::OUT_NOT_FOUND;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (run_i) begin
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        priority if (sts_i.bad_coord) begin
          state_d = StNotFound;
        end else if (sts_i.same_cell) begin
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = gaps_pkg::OUT_START;
            state_d        = StIdle;
          end
        end else begin
          cmd_o.init = 1'b1;
          state_d    = StPopDec;
        end
      end
      StPopDec: begin
        if (!sts_i.open_any) begin
          state_d = StNotFound;
        end else begin
          cmd_o.scan_clr = 1'b1;
          state_d        = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.pop = 1'b1;
          state_d   = StExpand;
        end
      end
      StExpand: begin
        cmd_o.expand = 1'b1;
        priority if (sts_i.goal_hit) begin
          cmd_o.trace_init = 1'b1;
          state_d          = StTrace;
        end else if (sts_i.dir_last) begin
          state_d = StPopDec;
        end
      end
      StTrace: begin
        cmd_o.trace_step = 1'b1;
        state_d = sts_i.trace_end ? StEmitRd : StTraceWait;
      end
      StTraceWait: begin
        cmd_o.trace_load = 1'b1;
        state_d          = StTrace;
      end
      StEmitRd: begin
        state_d = StEmitOut;
      end
      StEmitOut: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = gaps_pkg::OUT_CHAIN;
          if (sts_i.emit_first) begin
            state_d = StIdle;
          end else begin
            cmd_o.emit_dec = 1'b1;
            state_d        = StEmitRd;
          end
        end
      end
      StNotFound: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `GAPS_ASSERT(a_load_free, cmd_o.out_load |-> sts_i.out_free)
  `GAPS_ASSERT_NEXT(a_run_busy, in_valid_i && !in_stall_o && run_i, in_stall_o)

endmodule

FILE: tb/sv/gaps_path_checker.sv
// Path checker for the grid path search block: watches both channels and
// predicts every path from its own copy of the map. Depends on gaps_pkg.
module gaps_path_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  gaps_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  gaps_pkg::out_item_t out_data_i,
  output int                  pending_o,
  output int                  fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Side = 8;

  logic                map_open[64];
  logic [15:0]         best_f[64];
  logic                closed[64];
  logic [5:0]          parent[64];
  logic [37:0]         open_set[64];
  int                  open_cnt;
  gaps_pkg::out_item_t path_q[$];
  int                  fails;

  assign pending_o    = path_q.size();
  assign fail_count_o = fails;

  function automatic int dist_cost(int x, int y, int gx, int gy);
    int ax;
    int ay;
    ax = (x > gx) ? x - gx : gx - x;
    ay = (y > gy) ? y - gy : gy - y;
    return gaps_pkg::CostDiagonal * ((ax > ay) ? ax : ay);
  endfunction

  function automatic gaps_pkg::out_item_t path_cell(int cid, bit lst, bit nf);
    gaps_pkg::out_item_t r;
    r.path_x    = 3'(cid % 8);
    r.path_y    = 3'(cid / 8);
    r.last      = lst;
    r.not_found = nf;
    return r;
  endfunction

  // Appends one expected path cell behind those already waiting.
  task automatic add_expected(gaps_pkg::out_item_t it);
    path_q.insert(path_q.size(), it);
  endtask

  // Searches from start to goal and queues the expected path cells.
  task automatic predict_path(int sx, int sy, int gx, int gy);
    int dxs[8];
    int dys[8];
    int start;
    int goal;
    int cur;
    int g0;
    int nx;
    int ny;
    int nc;
    int g;
    int f;
    int bi;
    int n;
    int chain[64];
    bit found;
    logic [37:0] key;
    dxs = '{-1, 0, 1, 0, -1, 1, 1, -1};
    dys = '{0, -1, 0, 1, -1, -1, 1, 1};
    start = sy * 8 + sx;
    goal  = gy * 8 + gx;
    found = 0;
    if (start == goal) begin
      add_expected(path_cell(start, 1, 0));
      return;
    end
    for (int i = 0; i < 64; i++) begin
      best_f[i] = 16'hffff;
      closed[i] = 0;
    end
    closed[start] = 1;
    best_f[start] = 16'(dist_cost(sx, sy, gx, gy));
    parent[start] = 6'(start);
    open_set[0] = {best_f[start], 16'd0, 6'(start)};
    open_cnt = 1;
    while (!found && open_cnt > 0) begin
      bi = 0;
      for (int i = 1; i < open_cnt; i++) if (open_set[i] < open_set[bi]) bi = i;
      key = open_set[bi];
      open_cnt--;
      open_set[bi] = open_set[open_cnt];
      cur = key[5:0];
      g0 = key[21:6];
      for (int d = 0; d < 8; d++) begin
        nx = cur % 8 + dxs[d];
        ny = cur / 8 + dys[d];
        if (nx < 0 || ny < 0 || nx >= Side || ny >= Side) continue;
        nc = ny * 8 + nx;
        if (nc == goal) begin
          parent[nc] = 6'(cur);
          found = 1;
          break;
        end
        if (!map_open[nc] || closed[nc]) continue;
        g = g0 + ((d >= 4) ? gaps_pkg::CostDiagonal : gaps_pkg::CostStraight);
        f = g + dist_cost(nx, ny, gx, gy);
        if (f > 16'hffff) f = 16'hffff;
        if (best_f[nc] <= f) continue;
        closed[nc] = 1;
        best_f[nc] = 16'(f);
        parent[nc] = 6'(cur);
        if (open_cnt < 64) begin
          open_set[open_cnt] = {16'(f), 16'(g), 6'(nc)};
          open_cnt++;
        end
      end
    end
    if (!found) begin
      add_expected(path_cell(0, 1, 1));
      return;
    end
    n = 1;
    chain[0] = goal;
    while (n < 64 && chain[n-1] != start) begin
      chain[n] = parent[chain[n-1]];
      n++;
    end
    for (int k = 0; k < n; k++) add_expected(path_cell(chain[n-1-k], k == n - 1, 0));
  endtask

  initial begin
    fails = 0;
    open_cnt = 0;
    for (int i = 0; i < 64; i++) begin
      map_open[i] = 0;
      parent[i] = '0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_i) begin
      if (in_data_i.operation == 1'b0) begin
        map_open[in_data_i.cell_y * 8 + in_data_i.cell_x] = in_data_i.passable;
      end else begin
        predict_path(in_data_i.start_x, in_data_i.start_y, in_data_i.goal_x, in_data_i.goal_y);
      end
    end
  end

  always @(posedge clk_i) begin
    gaps_pkg::out_item_t want;
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (path_q.size() == 0) begin
        if (fails < 10) $display("unexpected path cell %p", out_data_i);
        fails++;
      end else begin
        want = path_q.pop_front();
        if (out_data_i.path_x !== want.path_x || out_data_i.path_y !== want.path_y ||
            out_data_i.last !== want.last || out_data_i.not_found !== want.not_found) begin
          if (fails < 10) $display("path cell mismatch: expected %p, got %p", want, out_data_i);
          fails++;
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb_grid_astar_path_search_top.sv
// Testbench top for grid_astar_path_search_top: loads maps, starts searches
// and gives the verdict. Depends on gaps_pkg, the block and gaps_path_checker.
module tb_grid_astar_path_search_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall;
  gaps_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  gaps_pkg::out_item_t out_data;
  int                  pending;
  int                  fail_count;
  bit                  quiet_tail;
  int                  cells_out;
  int                  idle_cycles;

  grid_astar_path_search_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  gaps_path_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // Offers one transaction and waits until the block takes it.
  task automatic offer(gaps_pkg::in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic load_cell(int x, int y, bit pass);
    gaps_pkg::in_item_t it;
    it = gaps_pkg::in_item_t'($urandom);
    it.operation = 1'b0;
    it.cell_x = 3'(x);
    it.cell_y = 3'(y);
    it.passable = pass;
    offer(it);
  endtask

  task automatic search(int sx, int sy, int gx, int gy);
    gaps_pkg::in_item_t it;
    it = gaps_pkg::in_item_t'($urandom);
    it.operation = 1'b1;
    it.start_x = 3'(sx);
    it.start_y = 3'(sy);
    it.goal_x = 3'(gx);
    it.goal_y = 3'(gy);
    offer(it);
  endtask

  // Receiver: short random stalls, and one long hold once a few cells came out.
  initial begin
    bit held;
    held = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && cells_out >= 3) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk_i);
        out_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3) - 1) @(posedge clk_i);
        @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_out   <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) cells_out <= cells_out + 1;
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL grid_astar_path_search_top");
        $finish;
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    quiet_tail = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fully blocked map: neighbor goal, trapped start, start equals goal.
    search(0, 0, 1, 1);
    search(0, 0, 7, 7);
    search(3, 3, 3, 3);
    search(7, 7, 7, 6);
    // A corridor along the top row and down the right column.
    for (int i = 1; i < 7; i++) load_cell(i, 0, 1);
    for (int i = 1; i < 7; i++) load_cell(7, i, 1);
    search(0, 0, 7, 7);
    search(7, 7, 0, 0);
    load_cell(7, 7, 0);
    search(0, 0, 7, 7);

    // Random part: mostly open maps so that searches reach far.
    for (int n = 0; n < 170; n++) begin
      if (n >= 140) quiet_tail = 1;
      if ($urandom_range(0, 9) < 7)
        load_cell($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 4) != 0);
      else
        search($urandom_range(0, 7), $urandom_range(0, 7),
               $urandom_range(0, 7), $urandom_range(0, 7));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("PASS grid_astar_path_search_top");
    else $display("FAIL grid_astar_path_search_top");
    $finish;
  end

endmodule
